// File: rtl/pgdc_pkg.sv
package pgdc_pkg;

    // Field widths.
    localparam int RANGE_W = 12;
    localparam int TIME_W  = 32;
    localparam int DUR_W   = 16;
    localparam int SPEED_W = 10;
    localparam int CFG_W   = 16;

    // Stream word widths, padded up to whole bytes.
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;

    // Wheel commands in signed Q1.8.
    localparam logic signed [SPEED_W-1:0] FULL_SPEED  = 10'sd256;
    localparam logic signed [SPEED_W-1:0] PIVOT_SPEED = 10'sd205;
    localparam logic signed [SPEED_W-1:0] ZERO_SPEED  = 10'sd0;

    // Register reset values.
    localparam logic [RANGE_W-1:0] EMERGENCY_RST  = 12'd50;
    localparam logic [RANGE_W-1:0] TOGGLE_FAR_RST = 12'd150;
    localparam logic [RANGE_W-1:0] LEFT_FAR_RST   = 12'd250;
    localparam logic [RANGE_W-1:0] RIGHT_FAR_RST  = 12'd400;
    localparam logic [DUR_W-1:0]   HOLD_RST       = 16'd600;
    localparam logic [DUR_W-1:0]   LEFT_TURN_RST  = 16'd400;
    localparam logic [DUR_W-1:0]   RIGHT_TURN_RST = 16'd400;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_MODE       = 3'd0,
        REG_EMERGENCY  = 3'd1,
        REG_TOGGLE_FAR = 3'd2,
        REG_LEFT_FAR   = 3'd3,
        REG_RIGHT_FAR  = 3'd4,
        REG_HOLD       = 3'd5,
        REG_LEFT_TURN  = 3'd6,
        REG_RIGHT_TURN = 3'd7
    } cfg_reg_t;

endpackage

// File: rtl/proximity_gesture_drive_control.sv
// A reading transferred into the input register has its result loaded into the result
// register, together with the gesture state update, once the result register is empty or
// being drained; m_tvalid is driven straight from the result register.
// Throughput: one reading per cycle while m_tready does not stall the result stream.
// Reset: aresetn is synchronous and active low; it clears both pipeline stages, the
// gesture state and restores every configuration register to its default value.
module proximity_gesture_drive_control (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [11:0] range_mm, [43:12] now_ms, [47:44] zero
    input  logic [pgdc_pkg::S_TDATA_W-1:0]    s_tdata,
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [9:0] left_speed, [19:10] right_speed, [20] is_running, [21] is_turning,
    // [23:22] zero
    output logic [pgdc_pkg::M_TDATA_W-1:0]    m_tdata,
    // Configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [2:0]                        cfg_index,
    input  logic [pgdc_pkg::CFG_W-1:0]        cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always accepted; the user must issue them only
    // while the block is idle, so no hazard with items in flight. The block does not enforce this.
    // ------------------------------------------------------------------
    logic                              mode_reg;
    logic [pgdc_pkg::RANGE_W-1:0]      emergency_mm_reg;
    logic [pgdc_pkg::RANGE_W-1:0]      toggle_far_mm_reg;
    logic [pgdc_pkg::RANGE_W-1:0]      left_far_mm_reg;
    logic [pgdc_pkg::RANGE_W-1:0]      right_far_mm_reg;
    logic [pgdc_pkg::DUR_W-1:0]        hold_ms_reg;
    logic [pgdc_pkg::DUR_W-1:0]        left_turn_ms_reg;
    logic [pgdc_pkg::DUR_W-1:0]        right_turn_ms_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= 1'b0;
            emergency_mm_reg  <= pgdc_pkg::EMERGENCY_RST;
            toggle_far_mm_reg <= pgdc_pkg::TOGGLE_FAR_RST;
            left_far_mm_reg   <= pgdc_pkg::LEFT_FAR_RST;
            right_far_mm_reg  <= pgdc_pkg::RIGHT_FAR_RST;
            hold_ms_reg       <= pgdc_pkg::HOLD_RST;
            left_turn_ms_reg  <= pgdc_pkg::LEFT_TURN_RST;
            right_turn_ms_reg <= pgdc_pkg::RIGHT_TURN_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (pgdc_pkg::cfg_reg_t'(cfg_index))
                pgdc_pkg::REG_MODE:       mode_reg          <= cfg_data[0];
                pgdc_pkg::REG_EMERGENCY:  emergency_mm_reg  <= cfg_data[11:0];
                pgdc_pkg::REG_TOGGLE_FAR: toggle_far_mm_reg <= cfg_data[11:0];
                pgdc_pkg::REG_LEFT_FAR:   left_far_mm_reg   <= cfg_data[11:0];
                pgdc_pkg::REG_RIGHT_FAR:  right_far_mm_reg  <= cfg_data[11:0];
                pgdc_pkg::REG_HOLD:       hold_ms_reg       <= cfg_data;
                pgdc_pkg::REG_LEFT_TURN:  left_turn_ms_reg  <= cfg_data;
                pgdc_pkg::REG_RIGHT_TURN: right_turn_ms_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control. Stage one is the input register, stage two the
    // result register. Stage one moves forward whenever stage two is empty
    // or being drained, so a waiting result never blocks the next input
    // transfer while stage one is free.
    // ------------------------------------------------------------------
    logic                              in_valid_reg;
    logic [pgdc_pkg::RANGE_W-1:0]      in_range_reg;
    logic [pgdc_pkg::TIME_W-1:0]       in_now_reg;
    logic                              out_valid_reg;
    logic [pgdc_pkg::M_TDATA_W-1:0]    out_data_reg;
    logic                              out_free;
    logic                              advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_range_reg <= s_tdata[11:0];
            in_now_reg   <= s_tdata[43:12];
        end
    end

    // ------------------------------------------------------------------
    // Gesture state.
    // ------------------------------------------------------------------
    logic                                running_reg, running_next;
    logic                                turning_reg, turning_next;
    logic                                turn_is_left_reg, turn_is_left_next;
    logic [pgdc_pkg::TIME_W-1:0]         turn_started_reg, turn_started_next;
    logic                                toggle_armed_reg, toggle_armed_next;
    logic                                in_hold_zone_reg, in_hold_zone_next;
    logic [pgdc_pkg::TIME_W-1:0]         hold_started_reg, hold_started_next;
    logic signed [pgdc_pkg::SPEED_W-1:0] left_cmd_reg, left_cmd_next;
    logic signed [pgdc_pkg::SPEED_W-1:0] right_cmd_reg, right_cmd_next;

    // Zone decode of the registered reading. A zero reading means no echo
    // and never lands in the emergency or hold zones.
    logic                              echo;
    logic                              emergency;
    logic                              hand;
    logic                              left_zone;
    logic                              right_zone;
    logic [pgdc_pkg::DUR_W-1:0]        turn_dur;
    logic [pgdc_pkg::TIME_W-1:0]       turn_elapsed;
    logic [pgdc_pkg::TIME_W-1:0]       hold_elapsed;
    logic                              turn_done;
    logic                              hold_done;

    assign echo       = (in_range_reg != '0);
    assign emergency  = echo && (in_range_reg < emergency_mm_reg);
    assign hand       = echo && (in_range_reg < toggle_far_mm_reg);
    assign left_zone  = (in_range_reg >= toggle_far_mm_reg) && (in_range_reg < left_far_mm_reg);
    assign right_zone = (in_range_reg >= left_far_mm_reg) && (in_range_reg < right_far_mm_reg);

    // Elapsed times wrap modulo 2^32 like the timestamp itself.
    assign turn_dur     = turn_is_left_reg ? left_turn_ms_reg : right_turn_ms_reg;
    assign turn_elapsed = in_now_reg - turn_started_reg;
    assign hold_elapsed = in_now_reg - hold_started_reg;
    assign turn_done    = (turn_elapsed >= {16'd0, turn_dur});
    assign hold_done    = (hold_elapsed >= {16'd0, hold_ms_reg});

    always_comb begin
        running_next      = running_reg;
        turning_next      = turning_reg;
        turn_is_left_next = turn_is_left_reg;
        turn_started_next = turn_started_reg;
        toggle_armed_next = toggle_armed_reg;
        in_hold_zone_next = in_hold_zone_reg;
        hold_started_next = hold_started_reg;
        left_cmd_next     = left_cmd_reg;
        right_cmd_next    = right_cmd_reg;

        if (!mode_reg) begin
            // Stop mode zeroes the wheels but keeps the gesture state.
            left_cmd_next  = pgdc_pkg::ZERO_SPEED;
            right_cmd_next = pgdc_pkg::ZERO_SPEED;
        end else if (emergency) begin
            running_next   = 1'b0;
            turning_next   = 1'b0;
            left_cmd_next  = pgdc_pkg::ZERO_SPEED;
            right_cmd_next = pgdc_pkg::ZERO_SPEED;
        end else if (turning_reg) begin
            // Apart from the emergency check above, the reading is ignored until the pivot turn times out.
            if (turn_done) begin
                turning_next   = 1'b0;
                left_cmd_next  = pgdc_pkg::FULL_SPEED;
                right_cmd_next = pgdc_pkg::FULL_SPEED;
            end else if (turn_is_left_reg) begin
                left_cmd_next  = -pgdc_pkg::PIVOT_SPEED;
                right_cmd_next = pgdc_pkg::PIVOT_SPEED;
            end else begin
                left_cmd_next  = pgdc_pkg::PIVOT_SPEED;
                right_cmd_next = -pgdc_pkg::PIVOT_SPEED;
            end
        end else begin
            // Hold gesture: the first reading in the zone starts the timer,
            // a later one past the hold time toggles running and disarms.
            if (hand && toggle_armed_reg) begin
                if (!in_hold_zone_reg) begin
                    in_hold_zone_next = 1'b1;
                    hold_started_next = in_now_reg;
                end else if (hold_done) begin
                    running_next      = !running_reg;
                    toggle_armed_next = 1'b0;
                    in_hold_zone_next = 1'b0;
                end
            end else if (!hand) begin
                in_hold_zone_next = 1'b0;
                toggle_armed_next = 1'b1;
            end

            // The step that starts a turn keeps the previous commands.
            if (!running_next) begin
                left_cmd_next  = pgdc_pkg::ZERO_SPEED;
                right_cmd_next = pgdc_pkg::ZERO_SPEED;
            end else if (left_zone) begin
                turning_next      = 1'b1;
                turn_is_left_next = 1'b1;
                turn_started_next = in_now_reg;
            end else if (right_zone) begin
                turning_next      = 1'b1;
                turn_is_left_next = 1'b0;
                turn_started_next = in_now_reg;
            end else begin
                left_cmd_next  = pgdc_pkg::FULL_SPEED;
                right_cmd_next = pgdc_pkg::FULL_SPEED;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg      <= 1'b0;
            turning_reg      <= 1'b0;
            turn_is_left_reg <= 1'b0;
            turn_started_reg <= '0;
            toggle_armed_reg <= 1'b1;
            in_hold_zone_reg <= 1'b0;
            hold_started_reg <= '0;
            left_cmd_reg     <= pgdc_pkg::ZERO_SPEED;
            right_cmd_reg    <= pgdc_pkg::ZERO_SPEED;
        end else if (advance) begin
            running_reg      <= running_next;
            turning_reg      <= turning_next;
            turn_is_left_reg <= turn_is_left_next;
            turn_started_reg <= turn_started_next;
            toggle_armed_reg <= toggle_armed_next;
            in_hold_zone_reg <= in_hold_zone_next;
            hold_started_reg <= hold_started_next;
            left_cmd_reg     <= left_cmd_next;
            right_cmd_reg    <= right_cmd_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {2'b00, turning_next, running_next,
                             right_cmd_next, left_cmd_next};
        end
    end

`ifndef SYNTHESIS
    // A pivot turn can only start or continue while the robot is running.
    assert property (@(posedge aclk) disable iff (!aresetn)
        turning_reg |-> running_reg)
        else $error("turning while not running");

    // An emergency reading in automatic mode stops everything.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && mode_reg && emergency) |=>
            (!running_reg && !turning_reg && m_tdata[19:0] == '0))
        else $error("emergency stop not applied");

    // Stop mode always produces zero wheel commands.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !mode_reg) |=> (m_tvalid && m_tdata[19:0] == '0))
        else $error("nonzero speed in stop mode");

    // The left wheel command only ever takes one of the four legal speeds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (left_cmd_reg == pgdc_pkg::ZERO_SPEED) || (left_cmd_reg == pgdc_pkg::FULL_SPEED) ||
        (left_cmd_reg == pgdc_pkg::PIVOT_SPEED) || (left_cmd_reg == -pgdc_pkg::PIVOT_SPEED))
        else $error("illegal left wheel command");
`endif

endmodule
